// File: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FIELD_BITS    = 32;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  // operation codes as they arrive on the input word
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_CONJ,
    K_NONE
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]                   op;
    logic signed [FIELD_BITS-1:0] a_re;
    logic signed [FIELD_BITS-1:0] a_im;
    logic signed [FIELD_BITS-1:0] b_re;
    logic signed [FIELD_BITS-1:0] b_im;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] r_re;
    logic signed [FIELD_BITS-1:0] r_im;
    logic [1:0]                   status;
  } out_word_t;

endpackage

// File: src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts input words, classifies the operation and queues the operands.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  in_word_t                    in_word,
  output logic                        q_valid,
  output item_kind_t                  q_kind,
  output logic signed [WORD_BITS-1:0] q_a_re,
  output logic signed [WORD_BITS-1:0] q_a_im,
  output logic signed [WORD_BITS-1:0] q_b_re,
  output logic signed [WORD_BITS-1:0] q_b_im,
  input  logic                        q_pop
);

  localparam int W = WORD_BITS;

  item_kind_t              kind_mem [0:QDEPTH-1];
  logic signed [W-1:0]     a_re_mem [0:QDEPTH-1];
  logic signed [W-1:0]     a_im_mem [0:QDEPTH-1];
  logic signed [W-1:0]     b_re_mem [0:QDEPTH-1];
  logic signed [W-1:0]     b_im_mem [0:QDEPTH-1];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       cnt;
  logic [QCNT_W-1:0]       cnt_next;
  logic                    push;
  logic                    pop;
  item_kind_t              kind;

  always_comb begin
    unique case (in_word.op)
      OP_ADD:  kind = K_ADD;
      OP_SUB:  kind = K_SUB;
      OP_MUL:  kind = K_MUL;
      OP_DIV:  kind = K_DIV;
      OP_CONJ: kind = K_CONJ;
      default: kind = K_NONE;
    endcase
  end

  assign in_stall = (cnt == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign pop      = q_pop && q_valid;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 1'b1;
    end else if (pop && !push) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // keep the low word bits of each field as signed values
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr] <= kind;
      a_re_mem[wr_ptr] <= signed'(in_word.a_re[W-1:0]);
      a_im_mem[wr_ptr] <= signed'(in_word.a_im[W-1:0]);
      b_re_mem[wr_ptr] <= signed'(in_word.b_re[W-1:0]);
      b_im_mem[wr_ptr] <= signed'(in_word.b_im[W-1:0]);
    end
  end

  assign q_kind = kind_mem[rd_ptr];
  assign q_a_re = a_re_mem[rd_ptr];
  assign q_a_im = a_im_mem[rd_ptr];
  assign q_b_re = b_re_mem[rd_ptr];
  assign q_b_im = b_im_mem[rd_ptr];

endmodule

// File: src/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, scaling, a one-bit-per-stage divider
// and the output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  input  item_kind_t                  src_kind,
  input  logic signed [WORD_BITS-1:0] src_a_re,
  input  logic signed [WORD_BITS-1:0] src_a_im,
  input  logic signed [WORD_BITS-1:0] src_b_re,
  input  logic signed [WORD_BITS-1:0] src_b_im,
  output logic                        src_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output out_word_t                   out_word
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = 2 * W;
  localparam int PW = 2 * W + 2;
  localparam int RW = ((3 * W > 2 * W + F) ? 3 * W : 2 * W + F) + 1;

  localparam logic signed [PW-1:0] P_HI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] P_LO = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]         W_HI = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         W_LO = {1'b1, {(W-1){1'b0}}};

  // {saturated, value} of a word that grew by one bit
  function automatic logic [W:0] clip1(input logic signed [W:0] v);
    if (v[W] != v[W-1]) begin
      return {1'b1, v[W], {(W-1){~v[W]}}};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] clip_p(input logic signed [PW-1:0] v);
    if (v > P_HI) begin
      return {1'b1, W_HI};
    end else if (v < P_LO) begin
      return {1'b1, W_LO};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] clip_q(input logic neg, input logic over,
                                        input logic [W-1:0] q);
    logic sat;
    if (!neg) begin
      sat = over | q[W-1];
      return sat ? {1'b1, W_HI} : {1'b0, q};
    end
    sat = over | (q[W-1] & (|q[W-2:0]));
    return sat ? {1'b1, W_LO} : {1'b0, W'(-q)};
  endfunction

  logic en;
  assign en      = !out_valid || !out_stall;
  assign src_pop = en && src_valid;

  // ---------------- stage 1: products and the simple operations
  logic                 s1_valid;
  item_kind_t           s1_kind;
  logic signed [MW-1:0] s1_ac, s1_bd, s1_ad, s1_bc, s1_cc, s1_dd;
  logic [W-1:0]         s1_re, s1_im;
  logic                 s1_sat;
  logic [W:0]           c_re, c_im;
  logic [W-1:0]         e_re, e_im;
  logic                 e_sat;

  always_comb begin
    c_re  = '0;
    c_im  = '0;
    e_re  = '0;
    e_im  = '0;
    e_sat = 1'b0;
    unique case (src_kind)
      K_ADD: begin
        c_re = clip1((W+1)'(src_a_re) + (W+1)'(src_b_re));
        c_im = clip1((W+1)'(src_a_im) + (W+1)'(src_b_im));
        e_re = c_re[W-1:0];
        e_im = c_im[W-1:0];
        e_sat = c_re[W] | c_im[W];
      end
      K_SUB: begin
        c_re = clip1((W+1)'(src_a_re) - (W+1)'(src_b_re));
        c_im = clip1((W+1)'(src_a_im) - (W+1)'(src_b_im));
        e_re = c_re[W-1:0];
        e_im = c_im[W-1:0];
        e_sat = c_re[W] | c_im[W];
      end
      K_CONJ: begin
        c_im = clip1(-(W+1)'(src_a_im));
        e_re = src_a_re;
        e_im = c_im[W-1:0];
        e_sat = c_im[W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind <= src_kind;
      s1_ac   <= src_a_re * src_b_re;
      s1_bd   <= src_a_im * src_b_im;
      s1_ad   <= src_a_re * src_b_im;
      s1_bc   <= src_a_im * src_b_re;
      s1_cc   <= src_b_re * src_b_re;
      s1_dd   <= src_b_im * src_b_im;
      s1_re   <= e_re;
      s1_im   <= e_im;
      s1_sat  <= e_sat;
    end
  end

  // ---------------- stage 2: exact sums and the divisor
  logic                 s2_valid;
  item_kind_t           s2_kind;
  logic signed [PW-1:0] s2_sre, s2_sim;
  logic [MW-1:0]        s2_den;
  logic [W-1:0]         s2_re, s2_im;
  logic                 s2_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind <= s1_kind;
      if (s1_kind == K_MUL) begin
        s2_sre <= PW'(s1_ac) - PW'(s1_bd);
        s2_sim <= PW'(s1_ad) + PW'(s1_bc);
      end else begin
        s2_sre <= PW'(s1_ac) + PW'(s1_bd);
        s2_sim <= PW'(s1_bc) - PW'(s1_ad);
      end
      s2_den <= MW'(s1_cc) + MW'(s1_dd);
      s2_re  <= s1_re;
      s2_im  <= s1_im;
      s2_sat <= s1_sat;
    end
  end

  // ---------------- stage 3: scale products, set up the division
  logic signed [PW-1:0] t_re, t_im, mg_re, mg_im;
  logic [W:0]           m_re, m_im;
  logic [RW-1:0]        x_re, x_im, den_top;

  assign t_re    = s2_sre >>> F;
  assign t_im    = s2_sim >>> F;
  assign m_re    = clip_p(t_re);
  assign m_im    = clip_p(t_im);
  assign mg_re   = s2_sre[PW-1] ? -s2_sre : s2_sre;
  assign mg_im   = s2_sim[PW-1] ? -s2_sim : s2_sim;
  assign x_re    = RW'(mg_re[MW-1:0]) << F;
  assign x_im    = RW'(mg_im[MW-1:0]) << F;
  assign den_top = RW'(s2_den) << W;

  // index 0 is the stage 3 register, index W feeds the output register
  logic          dv_valid  [0:W];
  logic          dv_div    [0:W];
  logic          dv_divz   [0:W];
  logic [W-1:0]  dv_pre_re [0:W];
  logic [W-1:0]  dv_pre_im [0:W];
  logic          dv_pre_sat[0:W];
  logic          dv_neg_re [0:W];
  logic          dv_neg_im [0:W];
  logic          dv_ovr_re [0:W];
  logic          dv_ovr_im [0:W];
  logic [RW-1:0] dv_rem_re [0:W];
  logic [RW-1:0] dv_rem_im [0:W];
  logic [MW-1:0] dv_den    [0:W];
  logic [W-1:0]  dv_q_re   [0:W];
  logic [W-1:0]  dv_q_im   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_div[0]  <= (s2_kind == K_DIV);
      dv_divz[0] <= (s2_den == '0);
      if (s2_kind == K_MUL) begin
        dv_pre_re[0]  <= m_re[W-1:0];
        dv_pre_im[0]  <= m_im[W-1:0];
        dv_pre_sat[0] <= m_re[W] | m_im[W];
      end else begin
        dv_pre_re[0]  <= s2_re;
        dv_pre_im[0]  <= s2_im;
        dv_pre_sat[0] <= s2_sat;
      end
      dv_neg_re[0] <= s2_sre[PW-1];
      dv_neg_im[0] <= s2_sim[PW-1];
      dv_ovr_re[0] <= (x_re >= den_top);
      dv_ovr_im[0] <= (x_im >= den_top);
      dv_rem_re[0] <= x_re;
      dv_rem_im[0] <= x_im;
      dv_den[0]    <= s2_den;
      dv_q_re[0]   <= '0;
      dv_q_im[0]   <= '0;
    end
  end

  // ---------------- divider: one quotient bit per stage, high bit first
  for (genvar i = 1; i <= W; i++) begin : g_div
    logic [RW-1:0] dn;
    logic          ge_re, ge_im;

    assign dn    = RW'(dv_den[i-1]) << (W - i);
    assign ge_re = (dv_rem_re[i-1] >= dn);
    assign ge_im = (dv_rem_im[i-1] >= dn);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i] <= 1'b0;
      end else if (en) begin
        dv_valid[i] <= dv_valid[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_div[i]     <= dv_div[i-1];
        dv_divz[i]    <= dv_divz[i-1];
        dv_pre_re[i]  <= dv_pre_re[i-1];
        dv_pre_im[i]  <= dv_pre_im[i-1];
        dv_pre_sat[i] <= dv_pre_sat[i-1];
        dv_neg_re[i]  <= dv_neg_re[i-1];
        dv_neg_im[i]  <= dv_neg_im[i-1];
        dv_ovr_re[i]  <= dv_ovr_re[i-1];
        dv_ovr_im[i]  <= dv_ovr_im[i-1];
        dv_den[i]     <= dv_den[i-1];
        dv_rem_re[i]  <= ge_re ? dv_rem_re[i-1] - dn : dv_rem_re[i-1];
        dv_rem_im[i]  <= ge_im ? dv_rem_im[i-1] - dn : dv_rem_im[i-1];
        dv_q_re[i]    <= {dv_q_re[i-1][W-2:0], ge_re};
        dv_q_im[i]    <= {dv_q_im[i-1][W-2:0], ge_im};
      end
    end
  end

  // ---------------- result select and output register
  logic [W:0]   f_re, f_im;
  logic [W-1:0] r_re, r_im;
  logic [1:0]   r_st;

  assign f_re = clip_q(dv_neg_re[W], dv_ovr_re[W], dv_q_re[W]);
  assign f_im = clip_q(dv_neg_im[W], dv_ovr_im[W], dv_q_im[W]);

  always_comb begin
    if (!dv_div[W]) begin
      r_re = dv_pre_re[W];
      r_im = dv_pre_im[W];
      r_st = dv_pre_sat[W] ? ST_SAT : ST_OK;
    end else if (dv_divz[W]) begin
      r_re = '0;
      r_im = '0;
      r_st = ST_DIVZ;
    end else begin
      r_re = f_re[W-1:0];
      r_im = f_im[W-1:0];
      r_st = (f_re[W] | f_im[W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.r_re   <= FIELD_BITS'(signed'(r_re));
      out_word.r_im   <= FIELD_BITS'(signed'(r_im));
      out_word.status <= r_st;
    end
  end

endmodule

// File: src/complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex add, subtract, multiply, divide and conjugate in signed fixed point.
// ----------------------------------------------------------------------------
//   channel  | signals                         | word
//   ---------+---------------------------------+------------------------------
//   input    | in_valid, in_stall, in_word     | op, a_re, a_im, b_re, b_im
//   output   | out_valid, out_stall, out_word  | r_re, r_im, status
//
// One word is taken per cycle while in_stall is low; each result passes from
// the queue into three arithmetic stages, one divider stage per quotient bit
// and the output register. The divider length sets the latency.
// Reset is synchronous and clears the queue and all stage valid bits.
// A stall while out_valid is high freezes the pipeline; the queue fills to
// two words, then in_stall rises.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic                        q_valid;
  logic                        q_pop;
  item_kind_t                  q_kind;
  logic signed [WORD_BITS-1:0] q_a_re, q_a_im, q_b_re, q_b_im;

  cau_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_kind   (q_kind),
    .q_a_re   (q_a_re),
    .q_a_im   (q_a_im),
    .q_b_re   (q_b_re),
    .q_b_im   (q_b_im),
    .q_pop    (q_pop)
  );

  cau_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .src_valid (q_valid),
    .src_kind  (q_kind),
    .src_a_re  (q_a_re),
    .src_a_im  (q_a_im),
    .src_b_re  (q_b_re),
    .src_b_im  (q_b_im),
    .src_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
